// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// Checks that a condition holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

// ===== design/lpc_pkg.sv =====
package lpc_pkg;

  // Pipeline depth: darken multiply, reciprocal multiply, blend, result.
  localparam int unsigned NumStages = 4;

  localparam int unsigned PixW     = 8;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Darkening: numerator is (510 - m) * 5 * d + m, below 2^20.
  localparam int unsigned DarkNumW  = 20;
  localparam int unsigned DarkProdW = 40;
  localparam logic [8:0] ShadowFull = 9'd510;
  // floor(x / 2550) == (x * 842151) >> 31 for every x below 2^20.
  localparam logic [DarkNumW-1:0] DarkRecip = 20'd842151;
  localparam int unsigned DarkShift = 31;

  // Blend: weighted sum is below 2^16.
  localparam int unsigned BlendSumW  = 16;
  localparam int unsigned BlendProdW = 32;
  // floor(x / 255) == (x * 0x8081) >> 23 for every x up to 66051.
  localparam logic [BlendSumW-1:0] BlendRecip = 16'h8081;
  localparam int unsigned BlendShift = 23;

  // Register reset values.
  localparam logic [1:0]          ModeReset    = 2'd0;
  localparam logic [PixW-1:0]     OpacityReset = 8'd255;
  localparam logic [CfgDataW-1:0] KeyReset     = 24'hFFFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegLayerMode    = 2'd0,
    RegOpacity      = 2'd1,
    RegKeyColor     = 2'd2,
    RegShadowEnable = 2'd3
  } lpc_reg_e;

  typedef enum logic [1:0] {
    ModeOpaque = 2'd0,
    ModeBlend  = 2'd1,
    ModeKey    = 2'd2
  } lpc_mode_e;

  typedef struct packed {
    logic [PixW-1:0] dest_red;
    logic [PixW-1:0] dest_green;
    logic [PixW-1:0] dest_blue;
    logic [PixW-1:0] src_red;
    logic [PixW-1:0] src_green;
    logic [PixW-1:0] src_blue;
    logic            src_covers;
    logic [PixW-1:0] shadow_value;
  } lpc_in_t;

  typedef struct packed {
    logic [PixW-1:0] out_red;
    logic [PixW-1:0] out_green;
    logic [PixW-1:0] out_blue;
  } lpc_out_t;

  // Darkened destination and source between the two halves of the pipe.
  typedef struct packed {
    logic [NumChan-1:0][PixW-1:0] e;
    logic [NumChan-1:0][PixW-1:0] s;
    logic                         covers;
    logic                         key_hit;
  } lpc_mid_t;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [NumStages-1:0] load;
  } lpc_ctrl_t;

endpackage

// ===== design/lpc_ctrl.sv =====
module lpc_ctrl
  import lpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_stall_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output lpc_ctrl_t ctrl_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] en;

  // A stage may load when it is empty or when its contents move on.
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // Valid bits follow the data through the stages.
  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load = en;
  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

// ===== design/lpc_shadow.sv =====
module lpc_shadow
  import lpc_pkg::*;
(
  input  logic                clk_i,
  input  logic [1:0]          load_i,
  input  lpc_in_t             pix_i,
  input  logic                shadow_en_i,
  input  logic [CfgDataW-1:0] key_color_i,
  output lpc_mid_t            mid_o
);

  logic [NumChan-1:0][PixW-1:0]     d;
  logic [NumChan-1:0][PixW-1:0]     s;
  logic [8:0]                       inv_m;
  logic [11:0]                      weight;
  logic [NumChan-1:0][DarkNumW-1:0] num_d;
  logic [NumChan-1:0][DarkNumW-1:0] num_q;
  logic [NumChan-1:0][PixW-1:0]     d1_q;
  logic [NumChan-1:0][PixW-1:0]     s1_q;
  logic                             covers1_q;
  logic                             hit1_q;
  logic                             hit_d;
  logic [NumChan-1:0][DarkProdW-1:0] prod;
  lpc_mid_t                         mid_d;
  lpc_mid_t                         mid_q;

  assign d = {pix_i.dest_red, pix_i.dest_green, pix_i.dest_blue};
  assign s = {pix_i.src_red, pix_i.src_green, pix_i.src_blue};

  // First stage: darkening numerator (510 - m) * 5 * d + m per channel.
  assign inv_m  = ShadowFull - {1'b0, pix_i.shadow_value};
  assign weight = {1'b0, inv_m, 2'b00} + {3'b000, inv_m};
  assign hit_d  = (s == key_color_i);

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      num_d[c] = DarkNumW'(weight) * DarkNumW'(d[c]) + DarkNumW'(pix_i.shadow_value);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      num_q     <= num_d;
      d1_q      <= d;
      s1_q      <= s;
      covers1_q <= pix_i.src_covers;
      hit1_q    <= hit_d;
    end
  end

  // Second stage: divide by 2550 through the reciprocal multiply.
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod[c] = DarkProdW'(num_q[c]) * DarkProdW'(DarkRecip);
      mid_d.e[c] = shadow_en_i ? prod[c][DarkShift +: PixW] : d1_q[c];
    end
    mid_d.s       = s1_q;
    mid_d.covers  = covers1_q;
    mid_d.key_hit = hit1_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

// ===== design/lpc_blend.sv =====
module lpc_blend
  import lpc_pkg::*;
(
  input  logic            clk_i,
  input  logic [1:0]      load_i,
  input  lpc_mid_t        mid_i,
  input  logic [1:0]      mode_i,
  input  logic [PixW-1:0] opacity_i,
  output lpc_out_t        pix_o
);

  logic [PixW-1:0]                     inv_a;
  logic [NumChan-1:0][BlendSumW-1:0]   sum_d;
  logic [NumChan-1:0][BlendSumW-1:0]   sum_q;
  lpc_mid_t                            mid_q;
  logic [NumChan-1:0][BlendProdW-1:0]  prod;
  logic [NumChan-1:0][PixW-1:0]        res;
  lpc_out_t                            pix_d;
  lpc_out_t                            pix_q;

  // Third stage: weighted sum (255 - a) * e + a * s.
  assign inv_a = 8'd255 - opacity_i;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      sum_d[c] = BlendSumW'(inv_a) * BlendSumW'(mid_i.e[c])
               + BlendSumW'(opacity_i) * BlendSumW'(mid_i.s[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      sum_q <= sum_d;
      mid_q <= mid_i;
    end
  end

  // Fourth stage: divide by 255 and pick the result for the layer mode.
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod[c] = BlendProdW'(sum_q[c]) * BlendProdW'(BlendRecip);
      res[c]  = mid_q.e[c];
      if (mid_q.covers) begin
        case (mode_i)
          ModeOpaque: res[c] = mid_q.s[c];
          ModeBlend:  res[c] = prod[c][BlendShift +: PixW];
          ModeKey:    res[c] = mid_q.key_hit ? mid_q.e[c] : mid_q.s[c];
          default:    res[c] = mid_q.e[c];
        endcase
      end
    end
    pix_d.out_red   = res[2];
    pix_d.out_green = res[1];
    pix_d.out_blue  = res[0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// ===== design/layer_pixel_compositor_unit.sv =====
// An accepted request moves through the stage registers in order and shows at out_valid_o from the last one.
// Four stages (darken multiply, reciprocal multiply, blend, result); the first loads at the accepting edge.
// Throughput: one pixel per clock while the output is not stalled; each stage holds one pixel and refills as it drains.
// While the output is stalled, the empty stages behind it keep taking requests.
// Reset clears all stage valid bits and loads the register defaults:
// opaque mode, opacity 255, key color white, shadow off.
module layer_pixel_compositor_unit
  import lpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpc_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpc_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [1:0]          mode_q;
  logic [PixW-1:0]     opacity_q;
  logic [CfgDataW-1:0] key_q;
  logic                shadow_en_q;
  lpc_ctrl_t           ctrl;
  lpc_mid_t            mid;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeReset;
      opacity_q   <= OpacityReset;
      key_q       <= KeyReset;
      shadow_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lpc_reg_e'(cfg_index_i))
        RegLayerMode:    mode_q      <= cfg_data_i[1:0];
        RegOpacity:      opacity_q   <= cfg_data_i[PixW-1:0];
        RegKeyColor:     key_q       <= cfg_data_i;
        RegShadowEnable: shadow_en_q <= cfg_data_i[0];
        default:         mode_q      <= mode_q;
      endcase
    end
  end

  // Stage valid bits and load enables.
  lpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  // Shadow darkening and key compare.
  lpc_shadow u_shadow (
    .clk_i       (clk_i),
    .load_i      (ctrl.load[1:0]),
    .pix_i       (in_data_i),
    .shadow_en_i (shadow_en_q),
    .key_color_i (key_q),
    .mid_o       (mid)
  );

  // Blend and layer mode selection.
  lpc_blend u_blend (
    .clk_i     (clk_i),
    .load_i    (ctrl.load[3:2]),
    .mid_i     (mid),
    .mode_i    (mode_q),
    .opacity_i (opacity_q),
    .pix_o     (out_data_o)
  );

endmodule

// ===== design/lpc_checker.sv =====
`include "assert_macros.svh"

module lpc_checker
  import lpc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lpc_out_t            out_data_o
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled result keeps its value.
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))

  // The input only backs up when a result is waiting at a stalled output.
  `ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // With the output free, an accepted request comes out after four stages.
  `ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i, out_valid_o)

endmodule

bind layer_pixel_compositor_unit lpc_checker u_lpc_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import lpc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases = 12;
  localparam int unsigned PixelsPerPhase = 34;
  localparam int unsigned NumCases = 23;
  // Mode code that the package leaves unnamed; the layer draws nothing.
  localparam logic [1:0] ModeUnused = 2'd3;

  // One directed row: register settings, the pixel, and a typed-in result if obvious.
  typedef struct packed {
    logic [1:0]          mode;
    logic [PixW-1:0]     opacity;
    logic [CfgDataW-1:0] key;
    logic                shadow;
    lpc_in_t             px;
    logic                known;
    lpc_out_t            want;
  } pixel_case_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lpc_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lpc_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Expected pixel that travels with the request currently on the input.
  lpc_out_t in_want = '0;
  lpc_out_t pending_pixels[$];

  // Register copy used by the predictor.
  logic [1:0]          cfg_mode = ModeReset;
  logic [PixW-1:0]     cfg_opacity = OpacityReset;
  logic [CfgDataW-1:0] cfg_key = KeyReset;
  logic                cfg_shadow = 1'b0;

  logic calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned pixel_count = 0;
  int unsigned result_count = 0;
  int unsigned key_hit_count = 0;
  int unsigned setting_count = 0;

  pixel_case_t directed_cases [NumCases] = '{
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b0, {24'h000000, 24'hFFFFFF, 1'b1, 8'h00}, 1'b1, 24'hFFFFFF},
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b0, {24'hFFFFFF, 24'h000000, 1'b1, 8'h00}, 1'b1, 24'h000000},
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b0, {24'h123456, 24'hABCDEF, 1'b0, 8'h00}, 1'b1, 24'h123456},
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b0, {24'h000000, 24'h5A5A5A, 1'b1, 8'hFF}, 1'b1, 24'h5A5A5A},
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b1, {24'hFFFFFF, 24'h000000, 1'b0, 8'hFF}, 1'b1, 24'h7F7F7F},
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b1, {24'hFFFFFF, 24'h000000, 1'b0, 8'h00}, 1'b1, 24'hFFFFFF},
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b1, {24'h000000, 24'hFFFFFF, 1'b0, 8'hFF}, 1'b1, 24'h000000},
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b1, {24'h8040C0, 24'h0F1E2D, 1'b1, 8'h80}, 1'b1, 24'h0F1E2D},
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b1, {24'h8040C0, 24'h0F1E2D, 1'b0, 8'h80}, 1'b0, 24'h000000},
    '{ModeBlend,  8'd255, 24'hFFFFFF, 1'b0, {24'h000000, 24'hFFFFFF, 1'b1, 8'h00}, 1'b1, 24'hFFFFFF},
    '{ModeBlend,  8'd0,   24'hFFFFFF, 1'b0, {24'hABCDEF, 24'h123456, 1'b1, 8'h00}, 1'b1, 24'hABCDEF},
    '{ModeBlend,  8'd128, 24'hFFFFFF, 1'b1, {24'hFFFFFF, 24'h000000, 1'b1, 8'h00}, 1'b1, 24'h7F7F7F},
    '{ModeBlend,  8'd128, 24'hFFFFFF, 1'b1, {24'hC0C0C0, 24'h204060, 1'b1, 8'h9B}, 1'b0, 24'h000000},
    '{ModeBlend,  8'd77,  24'hFFFFFF, 1'b0, {24'h010203, 24'hFEFDFC, 1'b0, 8'h00}, 1'b1, 24'h010203},
    '{ModeKey,    8'd77,  24'hFFFFFF, 1'b0, {24'h102030, 24'hFFFFFF, 1'b1, 8'h00}, 1'b1, 24'h102030},
    '{ModeKey,    8'd77,  24'hFFFFFF, 1'b0, {24'h102030, 24'hFFFFFE, 1'b1, 8'h00}, 1'b1, 24'hFFFFFE},
    '{ModeKey,    8'd77,  24'h000000, 1'b0, {24'hFFFFFF, 24'h000000, 1'b1, 8'h00}, 1'b1, 24'hFFFFFF},
    '{ModeKey,    8'd77,  24'h123456, 1'b1, {24'hABCDEF, 24'h123456, 1'b1, 8'hFF}, 1'b0, 24'h000000},
    '{ModeKey,    8'd77,  24'h123456, 1'b1, {24'hABCDEF, 24'h123457, 1'b1, 8'hFF}, 1'b1, 24'h123457},
    '{ModeKey,    8'd77,  24'h123456, 1'b1, {24'hABCDEF, 24'h123457, 1'b0, 8'h40}, 1'b0, 24'h000000},
    '{ModeUnused, 8'd77,  24'h123456, 1'b0, {24'h000000, 24'hFFFFFF, 1'b1, 8'h00}, 1'b1, 24'h000000},
    '{ModeUnused, 8'd77,  24'h123456, 1'b1, {24'hFFFFFF, 24'h000000, 1'b1, 8'hFF}, 1'b1, 24'h7F7F7F},
    '{ModeOpaque, 8'd255, 24'hFFFFFF, 1'b0, {24'h000000, 24'h800000, 1'b1, 8'h00}, 1'b1, 24'h800000}
  };

  layer_pixel_compositor_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Composited pixel for the current register copy: optional shadow, then the layer mode.
  function automatic lpc_out_t composite_pixel(input lpc_in_t px);
    logic [PixW-1:0] dest [NumChan];
    logic [PixW-1:0] src [NumChan];
    logic [PixW-1:0] res [NumChan];
    int unsigned mask;
    int unsigned shaded;
    logic key_match;
    dest[0] = px.dest_red;
    dest[1] = px.dest_green;
    dest[2] = px.dest_blue;
    src[0] = px.src_red;
    src[1] = px.src_green;
    src[2] = px.src_blue;
    mask = px.shadow_value;
    key_match = ({px.src_red, px.src_green, px.src_blue} == cfg_key);
    for (int c = 0; c < NumChan; c++) begin
      shaded = cfg_shadow ? ((510 - mask) * 5 * dest[c] + mask) / 2550 : dest[c];
      res[c] = shaded[PixW-1:0];
      if (px.src_covers) begin
        case (cfg_mode)
          ModeOpaque: res[c] = src[c];
          ModeBlend: begin
            res[c] = 8'(((255 - cfg_opacity) * shaded + cfg_opacity * src[c]) / 255);
          end
          ModeKey: begin
            if (!key_match) res[c] = src[c];
          end
          default: ;
        endcase
      end
    end
    return {res[0], res[1], res[2]};
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Cycle limit guards against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timed out with %0d pixels still pending.", pending_pixels.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls at random, except during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 21);
  end

  // Check each delivered pixel against the oldest pending one, then record new requests.
  always @(posedge clk_i) begin
    lpc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %06h delivered with none pending", out_data_o));
      end else begin
        want = pending_pixels.pop_front();
        if (out_data_o.out_red !== want.out_red)
          report_mismatch($sformatf("red got %02h want %02h", out_data_o.out_red, want.out_red));
        if (out_data_o.out_green !== want.out_green)
          report_mismatch($sformatf("green got %02h want %02h", out_data_o.out_green,
                                    want.out_green));
        if (out_data_o.out_blue !== want.out_blue)
          report_mismatch($sformatf("blue got %02h want %02h", out_data_o.out_blue,
                                    want.out_blue));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_pixels.push_back(in_want);
      pixel_count++;
    end
  end

  // Present one pixel request, with random idle cycles ahead of it outside the calm stretch.
  task automatic send_pixel(input lpc_in_t px, input lpc_out_t want);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    in_want <= want;
    if (cfg_mode == ModeKey && px.src_covers && {px.src_red, px.src_green, px.src_blue} == cfg_key)
      key_hit_count++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold off new requests until every pending pixel has come out.
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
    repeat (NumStages) @(posedge clk_i);
  endtask

  task automatic write_reg(input lpc_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegLayerMode:    cfg_mode = value[1:0];
      RegOpacity:      cfg_opacity = value[PixW-1:0];
      RegKeyColor:     cfg_key = value;
      RegShadowEnable: cfg_shadow = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Settings change only with the pipe empty.
  task automatic apply_settings(input logic [1:0] mode, input logic [PixW-1:0] opacity,
                                input logic [CfgDataW-1:0] key, input logic shadow);
    drain_pixels();
    write_reg(RegLayerMode, CfgDataW'(mode));
    write_reg(RegOpacity, CfgDataW'(opacity));
    write_reg(RegKeyColor, key);
    write_reg(RegShadowEnable, CfgDataW'(shadow));
    setting_count++;
  endtask

  // Random pixel; in key mode the source often hits the key or misses it by one bit.
  function automatic lpc_in_t random_pixel();
    lpc_in_t px;
    px.dest_red = PixW'($urandom_range(0, 255));
    px.dest_green = PixW'($urandom_range(0, 255));
    px.dest_blue = PixW'($urandom_range(0, 255));
    px.src_red = PixW'($urandom_range(0, 255));
    px.src_green = PixW'($urandom_range(0, 255));
    px.src_blue = PixW'($urandom_range(0, 255));
    px.src_covers = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0: px.shadow_value = 8'h00;
      1: px.shadow_value = 8'hFF;
      default: px.shadow_value = PixW'($urandom_range(0, 255));
    endcase
    if (cfg_mode == ModeKey) begin
      case ($urandom_range(0, 4))
        0, 1: {px.src_red, px.src_green, px.src_blue} = cfg_key;
        2: {px.src_red, px.src_green, px.src_blue} = cfg_key ^ (24'd1 << $urandom_range(0, 23));
        default: ;
      endcase
    end
    return px;
  endfunction

  // Main sequence: reset, directed rows, random phases, then wind down.
  initial begin
    pixel_case_t row;
    lpc_in_t px;
    logic [1:0] mode;
    logic [PixW-1:0] opacity;
    logic [CfgDataW-1:0] key;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumCases; i++) begin
      row = directed_cases[i];
      if (row.mode != cfg_mode || row.opacity != cfg_opacity || row.key != cfg_key ||
          row.shadow != cfg_shadow) begin
        apply_settings(row.mode, row.opacity, row.key, row.shadow);
      end
      send_pixel(row.px, row.known ? row.want : composite_pixel(row.px));
    end

    for (int p = 0; p < NumPhases; p++) begin
      mode = 2'(p % 4);
      opacity = (p == 1) ? 8'd0 : (p == 5) ? 8'd255 : PixW'($urandom_range(0, 255));
      key = (p == 2) ? 24'h000000 : (p == 6) ? 24'hFFFFFF : CfgDataW'($urandom);
      apply_settings(mode, opacity, key, 1'((p / 2) % 2));
      calm = (p == 4 || p == 5);
      for (int n = 0; n < PixelsPerPhase; n++) begin
        px = random_pixel();
        send_pixel(px, composite_pixel(px));
      end
    end
    calm = 1'b0;

    drain_pixels();
    repeat (4 * NumStages) @(posedge clk_i);
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixels never delivered", pending_pixels.size()));
    $display("Composited %0d pixels (%0d checked) across %0d register settings,",
             pixel_count, result_count, setting_count);
    $display("covering all layer modes, shadow on and off, and %0d color-key hits.",
             key_hit_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
